>>> hw/rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

  // Coordinate and fixed-point geometry.
  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;
  localparam int CNT_BITS   = COORD_BITS + 1;
  localparam int Q_BITS     = COORD_BITS + 1 + FRAC_BITS;
  localparam int DIV_BITS   = $clog2(FRAC_BITS);
  localparam int CHAN_BITS  = 8;
  localparam int RGB_BITS   = 3 * CHAN_BITS;
  localparam int ARGB_BITS  = 4 * CHAN_BITS;

  localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

  // Command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FIRST,
    ST_ACTIVE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic last;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/dda_if.sv
`default_nettype none

// Command channel: one item per start or next request.
interface dda_cmd_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [dda_pkg::COORD_BITS-1:0] start_x;
  logic [dda_pkg::COORD_BITS-1:0] start_y;
  logic [dda_pkg::COORD_BITS-1:0] end_x;
  logic [dda_pkg::COORD_BITS-1:0] end_y;
  logic [dda_pkg::CHAN_BITS-1:0]  red;
  logic [dda_pkg::CHAN_BITS-1:0]  green;
  logic [dda_pkg::CHAN_BITS-1:0]  blue;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, red, green, blue,
    output ready
  );
endinterface

// Pixel channel: one item per emitted pixel.
interface dda_pix_if;
  logic                           valid;
  logic                           ready;
  logic [dda_pkg::COORD_BITS-1:0] pixel_x;
  logic [dda_pkg::COORD_BITS-1:0] pixel_y;
  logic [dda_pkg::ARGB_BITS-1:0]  pixel_colour;
  logic                           last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/dda_datapath.sv
`default_nettype none

module dda_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dda_pkg::ctrl_t                 ctrl,
  output dda_pkg::stat_t                      stat,
  input  wire logic [dda_pkg::COORD_BITS-1:0] start_x,
  input  wire logic [dda_pkg::COORD_BITS-1:0] start_y,
  input  wire logic [dda_pkg::COORD_BITS-1:0] end_x,
  input  wire logic [dda_pkg::COORD_BITS-1:0] end_y,
  input  wire logic [dda_pkg::CHAN_BITS-1:0]  red,
  input  wire logic [dda_pkg::CHAN_BITS-1:0]  green,
  input  wire logic [dda_pkg::CHAN_BITS-1:0]  blue,
  output logic      [dda_pkg::COORD_BITS-1:0] pixel_x,
  output logic      [dda_pkg::COORD_BITS-1:0] pixel_y,
  output logic      [dda_pkg::ARGB_BITS-1:0]  pixel_colour,
  output logic                                last_pixel
);

  localparam int C = dda_pkg::COORD_BITS;
  localparam int F = dda_pkg::FRAC_BITS;
  localparam int N = dda_pkg::CNT_BITS;
  localparam int Q = dda_pkg::Q_BITS;

  // Line state.
  logic [N-1:0]                 step_count;
  logic [N-1:0]                 pixel_index;
  logic [Q-1:0]                 acc_x;
  logic [Q-1:0]                 acc_y;
  logic                         neg_x;
  logic                         neg_y;
  logic [F-1:0]                 quo_x;
  logic [F-1:0]                 quo_y;
  logic [C-1:0]                 rem_x;
  logic [C-1:0]                 rem_y;
  logic [dda_pkg::DIV_BITS-1:0] div_cnt;
  logic [dda_pkg::RGB_BITS-1:0] held_colour;

  // Start set-up: magnitudes, signs and step count.
  logic         load_neg_x;
  logic         load_neg_y;
  logic [C-1:0] abs_x;
  logic [C-1:0] abs_y;
  logic [N-1:0] load_steps;

  always_comb begin
    load_neg_x = end_x < start_x;
    load_neg_y = end_y < start_y;
    abs_x      = load_neg_x ? start_x - end_x : end_x - start_x;
    abs_y      = load_neg_y ? start_y - end_y : end_y - start_y;
    load_steps = (abs_x > abs_y) ? {1'b0, abs_x} + N'(1) : {1'b0, abs_y} + N'(1);
  end

  // One restoring division step per axis: shift the remainder, subtract if it fits.
  logic [C:0] shl_x;
  logic [C:0] shl_y;
  logic       fit_x;
  logic       fit_y;

  always_comb begin
    shl_x = {rem_x, 1'b0};
    shl_y = {rem_y, 1'b0};
    fit_x = shl_x >= step_count;
    fit_y = shl_y >= step_count;
  end

  // Advance the coordinates by the signed increment.
  logic [Q-1:0] inc_x;
  logic [Q-1:0] inc_y;

  always_comb begin
    inc_x = {{(Q - F){1'b0}}, quo_x};
    inc_y = {{(Q - F){1'b0}}, quo_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (ctrl.load) begin
      div_cnt <= dda_pkg::DIV_BITS'(F - 1);
    end else if (ctrl.div_step) begin
      div_cnt <= div_cnt - dda_pkg::DIV_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      step_count  <= load_steps;
      pixel_index <= '0;
      acc_x       <= {1'b0, start_x, {F{1'b0}}};
      acc_y       <= {1'b0, start_y, {F{1'b0}}};
      neg_x       <= load_neg_x;
      neg_y       <= load_neg_y;
      rem_x       <= abs_x;
      rem_y       <= abs_y;
      quo_x       <= '0;
      quo_y       <= '0;
      held_colour <= {red, green, blue};
    end else if (ctrl.div_step) begin
      rem_x <= fit_x ? C'(shl_x - step_count) : shl_x[C-1:0];
      rem_y <= fit_y ? C'(shl_y - step_count) : shl_y[C-1:0];
      quo_x <= {quo_x[F-2:0], fit_x};
      quo_y <= {quo_y[F-2:0], fit_y};
    end else if (ctrl.emit) begin
      acc_x       <= neg_x ? acc_x - inc_x : acc_x + inc_x;
      acc_y       <= neg_y ? acc_y - inc_y : acc_y + inc_y;
      pixel_index <= pixel_index + N'(1);
    end
  end

  // Output register: the floor of the fixed-point coordinate.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      pixel_x      <= acc_x[F+C-1:F];
      pixel_y      <= acc_y[F+C-1:F];
      pixel_colour <= {dda_pkg::ALPHA_OPAQUE, held_colour};
      last_pixel   <= stat.last;
    end
  end

  always_comb begin
    stat.div_done = div_cnt == '0;
    stat.last     = ({1'b0, pixel_index} + (N + 1)'(1)) >= {1'b0, step_count};
  end

endmodule

`default_nettype wire

>>> hw/rtl/dda_controller.sv
`default_nettype none

module dda_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire dda_pkg::stat_t stat,
  output dda_pkg::ctrl_t      ctrl
);

  dda_pkg::state_t state;
  dda_pkg::state_t state_next;
  logic            out_valid_next;
  logic            slot_free;
  logic            accept;

  // The output register can take a pixel when empty or being drained.
  always_comb begin
    slot_free = !out_valid || out_ready;
    in_ready  = ((state == dda_pkg::ST_IDLE) || (state == dda_pkg::ST_ACTIVE)) && slot_free;
    accept    = in_valid && in_ready;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dda_pkg::ST_IDLE: begin
        if (accept && in_command == dda_pkg::CMD_START) begin
          state_next = dda_pkg::ST_DIVIDE;
        end
      end
      dda_pkg::ST_DIVIDE: begin
        if (stat.div_done) begin
          state_next = dda_pkg::ST_FIRST;
        end
      end
      dda_pkg::ST_FIRST: begin
        if (slot_free) begin
          state_next = stat.last ? dda_pkg::ST_IDLE : dda_pkg::ST_ACTIVE;
        end
      end
      dda_pkg::ST_ACTIVE: begin
        if (accept) begin
          if (in_command == dda_pkg::CMD_START) begin
            state_next = dda_pkg::ST_DIVIDE;
          end else if (stat.last) begin
            state_next = dda_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = dda_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl.load     = accept && in_command == dda_pkg::CMD_START;
    ctrl.div_step = state == dda_pkg::ST_DIVIDE;
    ctrl.emit     = ((state == dda_pkg::ST_ACTIVE) && accept &&
                     in_command == dda_pkg::CMD_NEXT) ||
                    ((state == dda_pkg::ST_FIRST) && slot_free);
  end

  // Output valid flag follows the emit and drain events.
  always_comb begin
    if (ctrl.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dda_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dda_line_rasterizer_unit.sv
// Start item: after acceptance the divider runs, then the first pixel is emitted once the
// output register is free; the per-step increments come from a restoring divider that
// yields one quotient bit per cycle for both axes at once. Next items: one pixel per cycle
// while the output is not stalled, set by the coordinate accumulators and the output register.
// Reset (rst, synchronous, active high) leaves no line active and the output empty.
`default_nettype none

module dda_line_rasterizer_unit (
  input  wire logic clk,
  input  wire logic rst,
  dda_cmd_if.sink   cmd,
  dda_pix_if.source pix
);

  dda_pkg::ctrl_t ctrl;
  dda_pkg::stat_t stat;

  dda_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_command (cmd.command),
    .in_ready   (cmd.ready),
    .out_valid  (pix.valid),
    .out_ready  (pix.ready),
    .stat       (stat),
    .ctrl       (ctrl)
  );

  dda_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .start_x      (cmd.start_x),
    .start_y      (cmd.start_y),
    .end_x        (cmd.end_x),
    .end_y        (cmd.end_y),
    .red          (cmd.red),
    .green        (cmd.green),
    .blue         (cmd.blue),
    .pixel_x      (pix.pixel_x),
    .pixel_y      (pix.pixel_y),
    .pixel_colour (pix.pixel_colour),
    .last_pixel   (pix.last_pixel)
  );

endmodule

`default_nettype wire
